[src/sovq_pkg.sv]
// Shared types, sizes and helpers for the sphere overlap query table.
// Used by the controller, the datapath and the top level; depends on nothing.
package sovq_pkg;

  localparam int ENTRIES_PER_TABLE = 32;
  localparam int COORD_BITS        = 16;
  localparam int MAX_RESULTS       = 32;

  localparam int IN_COORD_W = 16;
  localparam int RADIUS_W   = 16;
  localparam int INDEX_W    = 5;

  localparam int ADDR_W    = (ENTRIES_PER_TABLE > 1) ? $clog2(ENTRIES_PER_TABLE) : 1;
  localparam int WALK_W    = $clog2(ENTRIES_PER_TABLE + 1);
  localparam int IDXC_W    = (WALK_W > INDEX_W) ? WALK_W : INDEX_W;
  localparam int RAM_DEPTH = 2 * ENTRIES_PER_TABLE;
  localparam int RAM_AW    = ADDR_W + 1;

  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int LIM_W    = RADIUS_W + 1;
  localparam int LIM_SQ_W = 2 * LIM_W;
  localparam int CMP_W    = (SUM_W > LIM_SQ_W) ? SUM_W : LIM_SQ_W;

  localparam int HIT_W = $clog2(MAX_RESULTS);
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  localparam int signed COORD_MAX = (2 ** (COORD_BITS - 1)) - 1;
  localparam int signed COORD_MIN = -COORD_MAX - 1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_CHECK = 2'd2,
    OP_CLEAR = 2'd3
  } sovq_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT
  } sovq_state_e;

  typedef struct packed {
    sovq_op_e                      opcode;
    logic                          table_sel;
    logic [INDEX_W-1:0]            entry_index;
    logic signed [IN_COORD_W-1:0]  pos_x;
    logic signed [IN_COORD_W-1:0]  pos_y;
    logic signed [IN_COORD_W-1:0]  pos_z;
    logic [RADIUS_W-1:0]           radius_in;
    logic                          add_entry_radius;
  } sovq_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] match_index;
    logic               match_table;
    logic               found;
    logic               last;
  } sovq_out_t;

  typedef struct packed {
    logic [RADIUS_W-1:0]          radius;
    logic signed [COORD_BITS-1:0] z;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } sovq_sphere_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_entry;
    logic clr_table;
    logic load_query;
    logic load_check;
    logic load_base;
    logic issue;
    logic emit_load;
  } sovq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_ok;
    logic base_valid;
    logic walk_end;
    logic pipe_empty;
    logic out_free;
    logic emit_last;
  } sovq_sts_t;

  // Sign-extended input coordinate, saturated to the stored coordinate range.
  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [IN_COORD_W-1:0] raw
  );
    int signed v;
    v = int'(raw);
    if (v > COORD_MAX) begin
      v = COORD_MAX;
    end else if (v < COORD_MIN) begin
      v = COORD_MIN;
    end
    return COORD_BITS'(v);
  endfunction

endpackage

[src/sovq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sovq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/sovq_ctrl.sv]
// Controller state machine of the sphere overlap query table.
// Depends on sovq_pkg for the state, opcode, command and status types.
module sovq_ctrl
  import sovq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  sovq_op_e  opcode_i,
  input  sovq_sts_t sts_i,
  output sovq_cmd_t cmd_o,
  output logic      in_stall_o
);

  sovq_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (opcode_i)
            OP_QUERY: state_d = ST_WALK;
            OP_CHECK: state_d = (sts_i.idx_ok && sts_i.base_valid) ? ST_LOAD : ST_EMIT;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:  state_d = ST_WALK;
      ST_WALK: begin
        if (sts_i.walk_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (opcode_i)
            OP_WRITE: cmd_o.wr_entry   = sts_i.idx_ok;
            OP_CLEAR: cmd_o.clr_table  = 1'b1;
            OP_QUERY: cmd_o.load_query = 1'b1;
            OP_CHECK: cmd_o.load_check = 1'b1;
            default: ;
          endcase
        end
      end
      ST_LOAD: cmd_o.load_base = 1'b1;
      ST_WALK: cmd_o.issue     = !sts_i.walk_end;
      ST_EMIT: cmd_o.emit_load = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Results are only read out once every lookup of the walk has retired.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> sts_i.pipe_empty)
    else $error("result readout started with lookups still in flight");

  // The base entry of a check is taken in the cycle right after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> ($past(state_q) == ST_IDLE))
    else $error("base entry loaded outside the cycle after acceptance");

  // The input is open only while the controller idles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (state_q != ST_IDLE))
    else $error("input stall out of step with the controller state");

endmodule

[src/sovq_datapath.sv]
// Datapath of the sphere overlap query table: sphere RAM, valid bits, the
// distance pipeline, the match list and the output register. Uses sovq_pkg.
module sovq_datapath
  import sovq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sovq_in_t  in_data_i,
  input  sovq_cmd_t cmd_i,
  output sovq_sts_t sts_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sovq_out_t out_data_o
);

  // Query context.
  logic                         tab_q;
  logic [WALK_W-1:0]            walk_idx_q, walk_idx_d;
  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic [RADIUS_W-1:0]          rq_q;
  logic                         add_r_q;

  logic [ENTRIES_PER_TABLE-1:0] valid_q [2];

  // Match list bookkeeping.
  logic [CNT_W-1:0]   cnt_q;
  logic [HIT_W-1:0]   rd_ptr_q;

  // Pipeline.
  logic                     s1_act_q, s1_ok_q;
  logic [INDEX_W-1:0]       s1_idx_q;
  logic                     s2_act_q, s2_ok_q;
  logic [INDEX_W-1:0]       s2_idx_q;
  logic signed [DIFF_W-1:0] s2_dx_q, s2_dy_q, s2_dz_q;
  logic [LIM_W-1:0]         s2_lim_q;
  logic                     s3_act_q, s3_ok_q;
  logic [INDEX_W-1:0]       s3_idx_q;
  logic [SQ_W-1:0]          s3_sqx_q, s3_sqy_q, s3_sqz_q;
  logic [LIM_SQ_W-1:0]      s3_lim_sq_q;

  logic      out_valid_q;
  sovq_out_t out_data_q;

  // Index handling.
  logic              idx_ok;
  logic [ADDR_W-1:0] in_addr;
  logic [ADDR_W-1:0] walk_addr;
  logic              walk_end;

  assign idx_ok    = IDXC_W'(in_data_i.entry_index) < IDXC_W'(ENTRIES_PER_TABLE);
  assign in_addr   = ADDR_W'(in_data_i.entry_index);
  assign walk_addr = walk_idx_q[ADDR_W-1:0];
  assign walk_end  = walk_idx_q == WALK_W'(ENTRIES_PER_TABLE);

  // Sphere RAM.
  sovq_sphere_t wr_sphere;
  sovq_sphere_t rd_sphere;
  logic [RAM_AW-1:0] raddr;
  logic [$bits(sovq_sphere_t)-1:0] rdata;

  assign wr_sphere.x      = sat_coord(in_data_i.pos_x);
  assign wr_sphere.y      = sat_coord(in_data_i.pos_y);
  assign wr_sphere.z      = sat_coord(in_data_i.pos_z);
  assign wr_sphere.radius = in_data_i.radius_in;

  assign raddr = cmd_i.issue ? {tab_q, walk_addr} : {in_data_i.table_sel, in_addr};

  sovq_ram #(
    .WIDTH($bits(sovq_sphere_t)),
    .DEPTH(RAM_DEPTH)
  ) u_sphere_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_entry),
    .waddr_i({in_data_i.table_sel, in_addr}),
    .wdata_i(wr_sphere),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_sphere = sovq_sphere_t'(rdata);

  // Stage 1: coordinate differences and radius limit.
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [LIM_W-1:0]         lim;

  assign dx  = $signed({px_q[COORD_BITS-1], px_q}) -
               $signed({rd_sphere.x[COORD_BITS-1], rd_sphere.x});
  assign dy  = $signed({py_q[COORD_BITS-1], py_q}) -
               $signed({rd_sphere.y[COORD_BITS-1], rd_sphere.y});
  assign dz  = $signed({pz_q[COORD_BITS-1], pz_q}) -
               $signed({rd_sphere.z[COORD_BITS-1], rd_sphere.z});
  assign lim = LIM_W'(rq_q) + (add_r_q ? LIM_W'(rd_sphere.radius) : LIM_W'(0));

  // Stage 2: squares.
  logic signed [SQ_W-1:0] prod_x, prod_y, prod_z;
  logic [LIM_SQ_W-1:0]    lim_sq;

  assign prod_x = s2_dx_q * s2_dx_q;
  assign prod_y = s2_dy_q * s2_dy_q;
  assign prod_z = s2_dz_q * s2_dz_q;
  assign lim_sq = s2_lim_q * s2_lim_q;

  // Stage 3: sum and strict compare.
  logic [SUM_W-1:0] dist_sq;
  logic             hit;
  logic             record;

  assign dist_sq = SUM_W'(s3_sqx_q) + SUM_W'(s3_sqy_q) + SUM_W'(s3_sqz_q);
  assign hit     = CMP_W'(dist_sq) < CMP_W'(s3_lim_sq_q);
  assign record  = s3_act_q && s3_ok_q && hit && (cnt_q < CNT_W'(MAX_RESULTS));

  // Match list RAM. The read address runs one step ahead on each readout so
  // that the registered read already holds the entry the pointer moves to.
  logic [HIT_W-1:0]   hit_raddr;
  logic [INDEX_W-1:0] hit_rdata;

  assign hit_raddr = cmd_i.emit_load ? (rd_ptr_q + HIT_W'(1)) : rd_ptr_q;

  sovq_ram #(
    .WIDTH(INDEX_W),
    .DEPTH(MAX_RESULTS)
  ) u_hit_ram (
    .clk_i  (clk_i),
    .we_i   (record),
    .waddr_i(cnt_q[HIT_W-1:0]),
    .wdata_i(s3_idx_q),
    .raddr_i(hit_raddr),
    .rdata_o(hit_rdata)
  );

  // Result readout.
  logic      emit_last;
  sovq_out_t out_data_d;
  logic      out_free;

  assign emit_last = (cnt_q == '0) || ((CNT_W'(rd_ptr_q) + CNT_W'(1)) == cnt_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    out_data_d.match_table = tab_q;
    out_data_d.last        = emit_last;
    if (cnt_q == '0) begin
      out_data_d.match_index = '0;
      out_data_d.found       = 1'b0;
    end else begin
      out_data_d.match_index = hit_rdata;
      out_data_d.found       = 1'b1;
    end
  end

  always_comb begin
    walk_idx_d = walk_idx_q;
    if (cmd_i.load_query) begin
      walk_idx_d = '0;
    end else if (cmd_i.load_check) begin
      walk_idx_d = WALK_W'(in_data_i.entry_index) + WALK_W'(1);
    end else if (cmd_i.issue) begin
      walk_idx_d = walk_idx_q + WALK_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0]  <= '0;
      valid_q[1]  <= '0;
      walk_idx_q  <= '0;
      cnt_q       <= '0;
      rd_ptr_q    <= '0;
      s1_act_q    <= 1'b0;
      s2_act_q    <= 1'b0;
      s3_act_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_entry) begin
        valid_q[in_data_i.table_sel][in_addr] <= 1'b1;
      end
      if (cmd_i.clr_table) begin
        valid_q[in_data_i.table_sel] <= '0;
      end
      walk_idx_q <= walk_idx_d;
      if (cmd_i.load_query || cmd_i.load_check) begin
        cnt_q    <= '0;
        rd_ptr_q <= '0;
      end else begin
        if (record) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (cmd_i.emit_load) begin
          rd_ptr_q <= rd_ptr_q + HIT_W'(1);
        end
      end
      s1_act_q <= cmd_i.issue;
      s2_act_q <= s1_act_q;
      s3_act_q <= s2_act_q;
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      tab_q   <= in_data_i.table_sel;
      px_q    <= wr_sphere.x;
      py_q    <= wr_sphere.y;
      pz_q    <= wr_sphere.z;
      rq_q    <= in_data_i.radius_in;
      add_r_q <= in_data_i.add_entry_radius;
    end else if (cmd_i.load_check) begin
      tab_q <= in_data_i.table_sel;
    end else if (cmd_i.load_base) begin
      px_q    <= rd_sphere.x;
      py_q    <= rd_sphere.y;
      pz_q    <= rd_sphere.z;
      rq_q    <= rd_sphere.radius;
      add_r_q <= 1'b1;
    end

    s1_ok_q  <= valid_q[tab_q][walk_addr];
    s1_idx_q <= INDEX_W'(walk_idx_q);

    s2_ok_q  <= s1_ok_q;
    s2_idx_q <= s1_idx_q;
    s2_dx_q  <= dx;
    s2_dy_q  <= dy;
    s2_dz_q  <= dz;
    s2_lim_q <= lim;

    s3_ok_q     <= s2_ok_q;
    s3_idx_q    <= s2_idx_q;
    s3_sqx_q    <= unsigned'(prod_x);
    s3_sqy_q    <= unsigned'(prod_y);
    s3_sqz_q    <= unsigned'(prod_z);
    s3_lim_sq_q <= lim_sq;

    if (cmd_i.emit_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign sts_o.idx_ok     = idx_ok;
  assign sts_o.base_valid = valid_q[in_data_i.table_sel][in_addr];
  assign sts_o.walk_end   = walk_end;
  assign sts_o.pipe_empty = !(s1_act_q || s2_act_q || s3_act_q);
  assign sts_o.out_free   = out_free;
  assign sts_o.emit_last  = emit_last;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("match count beyond the result limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_query || cmd_i.load_check) |->
      !(s1_act_q || s2_act_q || s3_act_q))
    else $error("new query started over lookups still in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_load |=> (out_valid_q && (out_data_q.last == $past(emit_last))))
    else $error("loaded result not presented at the output");

endmodule

[src/sphere_overlap_query_table.sv]
// Top level of the sphere overlap query table.
// Depends on sovq_pkg, sovq_ctrl, sovq_datapath and sovq_ram.
//
// The block holds two tables of bounding spheres (colliders and projectiles)
// and answers overlap queries against them. Input transactions arrive on
// in_valid_i / in_stall_o with an sovq_in_t payload; a transaction is taken
// at a rising edge where in_valid_i is high and in_stall_o is low. Results
// leave on out_valid_o / out_stall_i with an sovq_out_t payload.
// A write or a clear yields no result and leaves the controller idle; the block is ready
// for the next transaction in the following cycle.
// A point query walks the selected table one entry per cycle through a
// three-stage distance pipeline fed by the sphere RAM's registered read port,
// then reads the matches out one per cycle while the output is not stalled.
// A check first loads its base entry and then walks only the entries above it;
// a check whose base entry is out of range or not valid skips the walk.
// Results come in ascending index order; the final one has last set, and an
// empty answer is a single result with found clear. The output register
// keeps a result while out_stall_i is high, and readout pauses meanwhile.
// in_stall_o is high whenever a query is in progress. The next transaction is
// taken as soon as the last result sits in the output register.
// Reset clears all valid bits at once, so both tables start empty; the
// sphere RAM itself is not cleared and needs no clearing pass.
module sphere_overlap_query_table
  import sovq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  sovq_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sovq_out_t out_data_o
);

  sovq_cmd_t cmd;
  sovq_sts_t sts;

  // The controller sequences each transaction; the datapath does the work.
  sovq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .opcode_i  (in_data_i.opcode),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_stall_o(in_stall_o)
  );

  sovq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

[sim/sovq_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard class for the sphere overlap query table testbench.
// Depends on sovq_pkg for the transaction types, opcodes and table sizes.
package sovq_tb_pkg;
  import sovq_pkg::*;

  class overlap_scoreboard;
    logic signed [COORD_BITS-1:0] center[2][ENTRIES_PER_TABLE][3];
    logic [RADIUS_W-1:0]          radius[2][ENTRIES_PER_TABLE];
    bit                           live[2][ENTRIES_PER_TABLE];
    sovq_out_t                    expected_q[$];
    int                           mismatches = 0;
    int                           results_seen = 0;

    // Input coordinates are sign-extended, then clamped to the stored range.
    function logic signed [COORD_BITS-1:0] saturate(logic signed [IN_COORD_W-1:0] raw);
      int v;
      v = int'(raw);
      if (v > COORD_MAX) begin
        v = COORD_MAX;
      end else if (v < COORD_MIN) begin
        v = COORD_MIN;
      end
      return v[COORD_BITS-1:0];
    endfunction

    function longint unsigned span_sq(int t, int i, longint pt[3]);
      longint d;
      longint unsigned s;
      s = 0;
      for (int k = 0; k < 3; k++) begin
        d = pt[k] - longint'(center[t][i][k]);
        s += longint'(d * d);
      end
      return s;
    endfunction

    function void push_result(int idx, int t, bit hit, bit tail);
      sovq_out_t r;
      r.match_index = INDEX_W'(idx);
      r.match_table = t[0];
      r.found       = hit;
      r.last        = tail;
      expected_q = {expected_q, r};
    endfunction

    // Update the table copy and queue every result this transaction causes.
    function void note_input(sovq_in_t item);
      int             t;
      int             idx;
      int             first;
      int             hit_idx[$];
      bit             has_base;
      bit             add_r;
      longint         pt[3];
      longint unsigned qr;
      longint unsigned lim;
      t   = int'(item.table_sel);
      idx = int'(item.entry_index);
      case (item.opcode)
        OP_WRITE: begin
          if (idx < ENTRIES_PER_TABLE) begin
            center[t][idx][0] = saturate(item.pos_x);
            center[t][idx][1] = saturate(item.pos_y);
            center[t][idx][2] = saturate(item.pos_z);
            radius[t][idx]    = item.radius_in;
            live[t][idx]      = 1'b1;
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < ENTRIES_PER_TABLE; i++) begin
            live[t][i] = 1'b0;
          end
        end
        default: begin
          has_base = 1'b1;
          if (item.opcode == OP_CHECK) begin
            // A check walks from the entry above the base, using stored radii only.
            if (idx >= ENTRIES_PER_TABLE || !live[t][idx]) begin
              has_base = 1'b0;
            end else begin
              for (int k = 0; k < 3; k++) begin
                pt[k] = longint'(center[t][idx][k]);
              end
              qr    = 64'(radius[t][idx]);
              add_r = 1'b1;
              first = idx + 1;
            end
          end else begin
            pt[0] = longint'(saturate(item.pos_x));
            pt[1] = longint'(saturate(item.pos_y));
            pt[2] = longint'(saturate(item.pos_z));
            qr    = 64'(item.radius_in);
            add_r = item.add_entry_radius;
            first = 0;
          end
          if (has_base) begin
            for (int i = first; i < ENTRIES_PER_TABLE && hit_idx.size() < MAX_RESULTS; i++) begin
              if (live[t][i]) begin
                lim = qr + (add_r ? longint'(radius[t][i]) : 0);
                if (span_sq(t, i, pt) < lim * lim) begin
                  hit_idx = {hit_idx, i};
                end
              end
            end
          end
          if (hit_idx.size() == 0) begin
            push_result(0, t, 1'b0, 1'b1);
          end else begin
            foreach (hit_idx[k]) begin
              push_result(hit_idx[k], t, 1'b1, k == hit_idx.size() - 1);
            end
          end
        end
      endcase
    endfunction

    task report(string msg);
      $display("[sb] mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(sovq_out_t got);
      sovq_out_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
        return;
      end
      want = expected_q.pop_front();
      if (got.match_index !== want.match_index) begin
        report($sformatf("result %0d match_index got %0d expected %0d",
                         results_seen, got.match_index, want.match_index));
      end
      if (got.match_table !== want.match_table) begin
        report($sformatf("result %0d match_table got %0d expected %0d",
                         results_seen, got.match_table, want.match_table));
      end
      if (got.found !== want.found) begin
        report($sformatf("result %0d found got %0d expected %0d",
                         results_seen, got.found, want.found));
      end
      if (got.last !== want.last) begin
        report($sformatf("result %0d last got %0d expected %0d",
                         results_seen, got.last, want.last));
      end
    endtask

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

endpackage

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Top-level testbench for sphere_overlap_query_table: drives directed and
// scene-based random transactions. Depends on sovq_pkg and sovq_tb_pkg.
module tb_top;
  import sovq_pkg::*;
  import sovq_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TOTAL_ITEMS  = 220;
  localparam int QUIET_ITEMS  = 40;
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD    = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  sovq_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  sovq_out_t out_data;

  overlap_scoreboard sb;
  int items_sent;
  // Set for the tail of the run: neither side idles any more.
  bit quiet;
  // Asks the result side for one long hold-off while the sender keeps going.
  bit hold_req;

  sphere_overlap_query_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result monitor. Outputs and our own stall are sampled at the edge, before
  // any nonblocking update of this time step lands.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
  end

  // Result side stall driver: random stall bursts, quiet stretches in between,
  // and one long hold-off on request. The long hold is
  // counted here so that the sender is free to keep offering transactions.
  initial begin : result_side
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (int c = 0; c < LONG_HOLD; c++) begin
          @(posedge clk);
        end
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Watchdog on total run length.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic sovq_in_t random_item();
    sovq_in_t it;
    it.opcode           = sovq_op_e'($urandom_range(0, 3));
    it.table_sel        = 1'($urandom_range(0, 1));
    it.entry_index      = INDEX_W'($urandom_range(0, ENTRIES_PER_TABLE - 1));
    it.pos_x            = 16'($urandom);
    it.pos_y            = 16'($urandom);
    it.pos_z            = 16'($urandom);
    it.radius_in        = 16'($urandom);
    it.add_entry_radius = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic sovq_in_t make_item(sovq_op_e op, int t, int idx, int x, int y, int z,
                                         int r, int add);
    sovq_in_t it;
    it.opcode           = op;
    it.table_sel        = 1'(t);
    it.entry_index      = INDEX_W'(idx);
    it.pos_x            = 16'(x);
    it.pos_y            = 16'(y);
    it.pos_z            = 16'(z);
    it.radius_in        = 16'(r);
    it.add_entry_radius = 1'(add);
    return it;
  endfunction

  // A coordinate scattered around a cluster center, clamped to 16 bits.
  function automatic int near(int base, int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return v;
  endfunction

  // Mostly radii on the scale of the cluster, with zero and full scale mixed in.
  function automatic int pick_radius(int rmax);
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      return 0;
    end else if (sel == 1) begin
      return 65535;
    end
    return $urandom_range(0, (rmax > 65535) ? 65535 : rmax);
  endfunction

  // Offer one transaction and hold it until the block takes it. Valid stays
  // high into the next transaction unless a random gap follows.
  task automatic send_item(input sovq_in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(item);
    items_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      in_data  <= random_item();
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Always lets at least one edge pass, so valid never toggles within a step.
  task automatic wait_drained();
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // One scene: optionally clear a table, populate it with spheres clustered
  // around a point, then query and cross-check that cluster. A small share of
  // transactions is pure noise.
  task automatic run_scene(input bit force_fill);
    int bx, by, bz;
    int t, spread, rmax, n_wr, n_q, idx, sel;
    bit fill;
    int used[$];
    sovq_in_t it;
    t = $urandom_range(0, 1);
    if ($urandom_range(0, 2) == 0) begin
      it = random_item();
      it.opcode    = OP_CLEAR;
      it.table_sel = 1'(t);
      send_item(it);
    end
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 100;
      2: spread = 3000;
      default: spread = 40000;
    endcase
    if ($urandom_range(0, 4) == 0) begin
      bx = $urandom_range(0, 1) ? 32767 : -32768;
      by = $urandom_range(0, 1) ? 32767 : -32768;
      bz = $urandom_range(0, 1) ? 32767 : -32768;
    end else begin
      bx = int'($urandom_range(0, 40000)) - 20000;
      by = int'($urandom_range(0, 40000)) - 20000;
      bz = int'($urandom_range(0, 40000)) - 20000;
    end
    rmax = 2 * spread + 200;
    fill = force_fill || ($urandom_range(0, 7) == 0);
    n_wr = fill ? ENTRIES_PER_TABLE : $urandom_range(1, 8);
    for (int k = 0; k < n_wr; k++) begin
      idx = fill ? k : $urandom_range(0, ENTRIES_PER_TABLE - 1);
      used = {used, idx};
      send_item(make_item(OP_WRITE, t, idx, near(bx, spread), near(by, spread),
                          near(bz, spread), pick_radius(rmax), $urandom_range(0, 1)));
    end
    n_q = $urandom_range(2, 5);
    for (int k = 0; k < n_q; k++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        send_item(make_item(OP_QUERY, t, $urandom_range(0, ENTRIES_PER_TABLE - 1),
                            near(bx, spread), near(by, spread), near(bz, spread),
                            pick_radius(rmax), $urandom_range(0, 1)));
      end else if (sel < 9) begin
        // Mostly checks of entries written in this scene; sometimes any index.
        idx = (sel == 8) ? $urandom_range(0, ENTRIES_PER_TABLE - 1)
                         : used[$urandom_range(0, used.size() - 1)];
        it = random_item();
        it.opcode      = OP_CHECK;
        it.table_sel   = 1'(t);
        it.entry_index = INDEX_W'(idx);
        send_item(it);
      end else begin
        send_item(random_item());
      end
    end
  endtask

  initial begin : stimulus
    bit hold_done;
    bit pause_done;
    sb         = new;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Queries against empty tables and a check of an entry
    // never written must each give the lone empty answer.
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 100, 1));
    send_item(make_item(OP_CHECK, 1, 7, 0, 0, 0, 0, 0));
    // Corner spheres at both coordinate extremes with full-scale radius.
    send_item(make_item(OP_WRITE, 0, 0, 32767, 32767, 32767, 65535, 0));
    send_item(make_item(OP_WRITE, 0, 31, -32768, -32768, -32768, 65535, 1));
    send_item(make_item(OP_WRITE, 0, 5, 0, 0, 0, 0, 0));
    send_item(make_item(OP_WRITE, 0, 6, 10, -10, 3, 20, 0));
    // A zero radius limit overlaps nothing, even at distance zero.
    send_item(make_item(OP_QUERY, 0, 5, 0, 0, 0, 0, 0));
    // Entry radii added in the first two; entry_index is ignored by a point query.
    send_item(make_item(OP_QUERY, 0, 31, 0, 0, 0, 0, 1));
    send_item(make_item(OP_QUERY, 0, 17, 32767, 32767, 32767, 65535, 1));
    send_item(make_item(OP_QUERY, 0, 0, -32768, -32768, -32768, 0, 0));
    // Checks ignore the query radius and the add flag in the transaction.
    send_item(make_item(OP_CHECK, 0, 0, 1234, -77, 5, 0, 0));
    send_item(make_item(OP_CHECK, 0, 5, -1, -1, -1, 65535, 1));
    // Nothing lies above the top entry.
    send_item(make_item(OP_CHECK, 0, 31, 0, 0, 0, 65535, 1));
    // Distance exactly at the limit is not an overlap; one unit inside is.
    send_item(make_item(OP_WRITE, 1, 3, 100, 100, 100, 50, 0));
    send_item(make_item(OP_WRITE, 1, 4, 150, 100, 100, 0, 1));
    send_item(make_item(OP_WRITE, 1, 9, 149, 100, 100, 0, 0));
    send_item(make_item(OP_CHECK, 1, 3, 0, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 1, 17, 100, 100, 150, 50, 0));
    send_item(make_item(OP_QUERY, 1, 17, 100, 100, 150, 51, 0));
    // Clearing one table leaves the other untouched.
    send_item(make_item(OP_CLEAR, 0, 9, -5, 6, -7, 8, 1));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 65535, 1));
    send_item(make_item(OP_QUERY, 1, 0, 100, 100, 100, 65535, 0));
    send_item(make_item(OP_WRITE, 0, 5, 0, 0, 0, 300, 0));
    send_item(make_item(OP_CHECK, 0, 5, 0, 0, 0, 0, 0));

    // A scene that writes every entry of one table, so that a query can reach the result cap.
    run_scene(1'b1);
    while (items_sent < TOTAL_ITEMS - QUIET_ITEMS) begin
      if (!hold_done && items_sent >= 80) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && items_sent >= 130) begin
        in_valid <= 1'b0;
        wait_drained();
        pause_done = 1'b1;
      end
      run_scene(1'b0);
    end
    quiet = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      run_scene(1'b0);
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
